/* rtl/core/hwh_pkg.sv */
// Shared types and constants for the hue-wrapping HSV to RGB converter.
`default_nettype none

package hwh_pkg;

  // Field widths
  localparam int unsigned InW   = 24;  // smooth iteration value, signed Q8
  localparam int unsigned CfgW  = 9;   // Q8 saturation / brightness
  localparam int unsigned HueW  = 9;   // hue angle 0..359
  localparam int unsigned ChanW = 8;   // output channel
  localparam int unsigned NumW  = 22;  // (part + m) * 60 in Q16
  localparam int unsigned ZW    = 14;  // floor(255 * num / 2^16)

  // Hue mapping: H = trunc((243 + 20*s) / 256)
  localparam logic [28:0] HueOffset = 29'd243;
  // Bias that lifts the most negative hue above zero; a multiple of 360
  localparam logic [21:0] HueBias   = 22'd655560;
  // ceil(2^30 / 360): exact quotient for every biased hue
  localparam logic [21:0] HueRecip  = 22'd2982617;
  localparam int unsigned HueRecipShift = 30;
  localparam logic [21:0] FullCircle = 22'd360;

  // Q8 one and sector width in degrees
  localparam logic [CfgW-1:0] OneQ8  = 9'd256;
  localparam logic [HueW-1:0] SecDeg = 9'd60;

  // ceil(2^20 / 60): exact quotient for every channel numerator
  localparam logic [14:0] ChanRecip = 15'd17477;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Register indexes of the config port
  typedef enum logic {
    RegSat = 1'b0,
    RegVal = 1'b1
  } hwh_reg_e;

  // Hue sector, named by the hue range it spans
  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } hwh_sector_e;

  // Current register values handed to the back end
  typedef struct packed {
    logic [CfgW-1:0] sat;
    logic [CfgW-1:0] val;
  } hwh_cfg_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } hwh_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/hwh_front.sv */
// Front end: accepts beats and reduces the smooth value to a hue 0..359.
`default_nettype none

module hwh_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [hwh_pkg::InW-1:0] smooth_iter_q8_i,
  input  wire hwh_pkg::hwh_qstat_t            qstat_i,
  output logic                                push_o,
  output logic [hwh_pkg::HueW-1:0]            hue_o
);

  logic              adv;
  logic              f1_valid_q, f2_valid_q, f3_valid_q, f4_valid_q;
  logic [28:0]       num_d, num_q;
  logic [28:0]       s_ext;
  logic [20:0]       u_d, u_q, u2_q;
  logic [21:0]       u_sum;
  logic              rnd;
  logic [42:0]       prod_d, prod_q;
  logic [12:0]       quo;
  logic [21:0]       rem, rem_fix;
  logic [hwh_pkg::HueW-1:0] hue_d, hue_q;

  // Whole pipeline moves unless the last stage is blocked by a full queue
  assign adv        = !(f4_valid_q && qstat_i.full);
  assign in_stall_o = !adv;
  assign push_o     = f4_valid_q && !qstat_i.full;
  assign hue_o      = hue_q;

  // F1: 243 + 20*s
  always_comb begin
    s_ext = {{5{smooth_iter_q8_i[hwh_pkg::InW-1]}}, smooth_iter_q8_i};
    num_d = (s_ext << 4) + (s_ext << 2) + hwh_pkg::HueOffset;
  end

  // F2: divide by 256 toward zero, then bias to a non-negative value
  always_comb begin
    rnd   = num_q[28] && (num_q[7:0] != 8'h00);
    u_sum = {num_q[28], num_q[28:8]} + 22'(rnd) + hwh_pkg::HueBias;
    u_d   = u_sum[20:0];
  end

  // F3: reciprocal multiply for the quotient by 360
  assign prod_d = 43'(u_q) * 43'(hwh_pkg::HueRecip);

  // F4: remainder by 360
  always_comb begin
    quo     = prod_q[42:hwh_pkg::HueRecipShift];
    rem     = {1'b0, u2_q} - 22'(22'(quo) * hwh_pkg::FullCircle);
    rem_fix = (rem >= hwh_pkg::FullCircle) ? rem - hwh_pkg::FullCircle : rem;
    hue_d   = rem_fix[hwh_pkg::HueW-1:0];
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
      f4_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
      f4_valid_q <= f3_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q  <= num_d;
      u_q    <= u_d;
      prod_q <= prod_d;
      u2_q   <= u_q;
      hue_q  <= hue_d;
    end
  end

  // Reduced hue is always a legal angle
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f4_valid_q |-> (hue_q < 9'd360))
    else $error("hue out of range");

endmodule

`default_nettype wire

/* rtl/core/hwh_fifo.sv */
// Short hue queue between the front and back ends.
`default_nettype none

module hwh_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [hwh_pkg::HueW-1:0]  wdata_i,
  input  wire logic                      pop_i,
  output logic [hwh_pkg::HueW-1:0]       rdata_o,
  output hwh_pkg::hwh_qstat_t            qstat_o
);

  logic [hwh_pkg::HueW-1:0]  mem_q [hwh_pkg::QDepth];
  logic [hwh_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [hwh_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == hwh_pkg::QCntW'(hwh_pkg::QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign rdata_o       = mem_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/hwh_back.sv */
// Back end: turns a hue and the current saturation/brightness into RGB.
`default_nettype none

module hwh_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hwh_pkg::hwh_qstat_t       qstat_i,
  input  wire logic [hwh_pkg::HueW-1:0]  hue_i,
  output logic                           pop_o,
  input  wire hwh_pkg::hwh_cfg_t         cfg_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [hwh_pkg::ChanW-1:0]      red_o,
  output logic [hwh_pkg::ChanW-1:0]      green_o,
  output logic [hwh_pkg::ChanW-1:0]      blue_o
);

  logic adv;
  logic b1_valid_q, b2_valid_q, b3_valid_q, b4_valid_q;

  // B1 signals
  hwh_pkg::hwh_sector_e     sector_d, sector_q;
  logic [hwh_pkg::HueW-1:0] hmod, hdist;
  logic [5:0]               tri_d, tri_q;
  logic [hwh_pkg::CfgW-1:0] sat_c, val_c;
  logic [16:0]              c16_d, c16_q, m16_d, m16_q;

  // B2..B4 signals, one lane per channel (red, green, blue)
  logic [hwh_pkg::NumW-1:0] c60, x60, m60;
  logic [hwh_pkg::NumW-1:0] part [3];
  logic [hwh_pkg::NumW-1:0] num_d [3];
  logic [hwh_pkg::NumW-1:0] num_q [3];
  logic [29:0]              y255 [3];
  logic [hwh_pkg::ZW-1:0]   z_d [3];
  logic [hwh_pkg::ZW-1:0]   z_q [3];
  logic [28:0]              zp [3];
  logic [hwh_pkg::ChanW-1:0] ch_d [3];
  logic [hwh_pkg::ChanW-1:0] ch_q [3];

  // Pipeline moves unless a finished result is held by the sink
  assign adv         = !(b4_valid_q && out_stall_i);
  assign pop_o       = adv && !qstat_i.empty;
  assign out_valid_o = b4_valid_q;
  assign red_o       = ch_q[0];
  assign green_o     = ch_q[1];
  assign blue_o      = ch_q[2];

  // B1: sector, triangle weight, chroma and offset
  always_comb begin
    if      (hue_i < 9'd60)  sector_d = hwh_pkg::SecRedYel;
    else if (hue_i < 9'd120) sector_d = hwh_pkg::SecYelGrn;
    else if (hue_i < 9'd180) sector_d = hwh_pkg::SecGrnCyn;
    else if (hue_i < 9'd240) sector_d = hwh_pkg::SecCynBlu;
    else if (hue_i < 9'd300) sector_d = hwh_pkg::SecBluMag;
    else                     sector_d = hwh_pkg::SecMagRed;

    if      (hue_i >= 9'd240) hmod = hue_i - 9'd240;
    else if (hue_i >= 9'd120) hmod = hue_i - 9'd120;
    else                      hmod = hue_i;
    hdist = (hmod >= hwh_pkg::SecDeg) ? hmod - hwh_pkg::SecDeg : hwh_pkg::SecDeg - hmod;
    tri_d = 6'(hwh_pkg::SecDeg - hdist);

    sat_c = (cfg_i.sat > hwh_pkg::OneQ8) ? hwh_pkg::OneQ8 : cfg_i.sat;
    val_c = (cfg_i.val > hwh_pkg::OneQ8) ? hwh_pkg::OneQ8 : cfg_i.val;
    c16_d = 17'(val_c) * 17'(sat_c);
    m16_d = 17'({val_c, 8'h00}) - c16_d;
  end

  // B2: scale to the common denominator and route by sector
  always_comb begin
    c60 = hwh_pkg::NumW'(c16_q) * hwh_pkg::NumW'(hwh_pkg::SecDeg);
    x60 = hwh_pkg::NumW'(c16_q) * hwh_pkg::NumW'(tri_q);
    m60 = hwh_pkg::NumW'(m16_q) * hwh_pkg::NumW'(hwh_pkg::SecDeg);
    part[0] = '0;
    part[1] = '0;
    part[2] = '0;
    case (sector_q)
      hwh_pkg::SecRedYel: begin part[0] = c60; part[1] = x60; end
      hwh_pkg::SecYelGrn: begin part[0] = x60; part[1] = c60; end
      hwh_pkg::SecGrnCyn: begin part[1] = c60; part[2] = x60; end
      hwh_pkg::SecCynBlu: begin part[1] = x60; part[2] = c60; end
      hwh_pkg::SecBluMag: begin part[0] = x60; part[2] = c60; end
      default:            begin part[0] = c60; part[2] = x60; end
    endcase
  end

  // B2..B4 per lane: add offset, times 255 over 2^16, then divide by 60
  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign num_d[i] = part[i] + m60;
    assign y255[i]  = 30'({num_q[i], 8'h00}) - 30'(num_q[i]);
    assign z_d[i]   = y255[i][29:16];
    assign zp[i]    = 29'(z_q[i]) * 29'(hwh_pkg::ChanRecip);
    assign ch_d[i]  = zp[i][27:20];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        num_q[i] <= num_d[i];
        z_q[i]   <= z_d[i];
        ch_q[i]  <= ch_d[i];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      b4_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= !qstat_i.empty;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
      b4_valid_q <= b3_valid_q;
    end
  end

  // B1 payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sector_q <= sector_d;
      tri_q    <= tri_d;
      c16_q    <= c16_d;
      m16_q    <= m16_d;
    end
  end

  // Triangle weight never exceeds a full sector
  a_tri_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_valid_q |-> (tri_q <= 6'd60))
    else $error("triangle weight out of range");

  // Chroma plus offset equals the clamped brightness, so never above one
  a_cm_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_valid_q |-> ((18'(c16_q) + 18'(m16_q)) <= 18'd65536))
    else $error("chroma plus offset above one");

endmodule

`default_nettype wire

/* rtl/core/hue_wrap_hsv_to_rgb.sv */
// Top level of the hue-wrapping HSV to RGB converter.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   in       | in_valid_i/in_stall_o   | smooth_iter_q8_i (24b signed Q8)
//   out      | out_valid_o/out_stall_i | red_o, green_o, blue_o (8b each)
//   config   | cfg_we_i                | cfg_addr_i (0 sat, 1 val), cfg_wdata_i
//
// One beat per clock sustained while the output is not stalled. A result passes
// through 4 hue stages, one write into the 4-entry queue and 4 color stages.
// Reset clears all valids and the queue and loads saturation 205, brightness 256.
// An output stall holds the color stages only; the front keeps accepting beats
// until the queue fills.
`default_nettype none

module hue_wrap_hsv_to_rgb (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [hwh_pkg::InW-1:0] smooth_iter_q8_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [hwh_pkg::ChanW-1:0]           red_o,
  output logic [hwh_pkg::ChanW-1:0]           green_o,
  output logic [hwh_pkg::ChanW-1:0]           blue_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_addr_i,
  input  wire logic [hwh_pkg::CfgW-1:0]       cfg_wdata_i
);

  hwh_pkg::hwh_cfg_t        cfg_q;
  hwh_pkg::hwh_qstat_t      qstat;
  hwh_pkg::hwh_reg_e        cfg_idx;
  logic                     push, pop;
  logic [hwh_pkg::HueW-1:0] hue_push, hue_head;

  assign cfg_idx = hwh_pkg::hwh_reg_e'(cfg_addr_i);

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sat <= 9'd205;
      cfg_q.val <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        hwh_pkg::RegSat: cfg_q.sat <= cfg_wdata_i;
        hwh_pkg::RegVal: cfg_q.val <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hwh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .smooth_iter_q8_i (smooth_iter_q8_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .hue_o            (hue_push)
  );

  hwh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (hue_push),
    .pop_i   (pop),
    .rdata_o (hue_head),
    .qstat_o (qstat)
  );

  hwh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .hue_i       (hue_head),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

`default_nettype wire

/* bench/hue_wrap_hsv_to_rgb_tb.sv */
// Self-checking testbench for the hue-wrapping HSV to RGB converter.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} pixel_t;

typedef struct packed {
  logic [23:0] smooth;
  pixel_t      px;
} pixel_expect_t;

// Keeps the register copies, predicts each pixel and checks arriving pixels in order
class pixel_ledger;
  logic [8:0]    sat_q8;
  logic [8:0]    bri_q8;
  pixel_expect_t pending_pixels[$];
  int unsigned   errors;

  function new();
    sat_q8 = 9'd205;
    bri_q8 = 9'd256;
    errors = 0;
  endfunction

  function void set_reg(hwh_pkg::hwh_reg_e idx, logic [8:0] value);
    if (idx == hwh_pkg::RegSat) begin
      sat_q8 = value;
    end else begin
      bri_q8 = value;
    end
  endfunction

  // floor(255 * num / (60 * 2^16))
  function automatic logic [7:0] scale_channel(longint num60);
    return 8'((num60 * 255) / (60 * 65536));
  endfunction

  function automatic pixel_t hsv_pixel(logic signed [23:0] s);
    longint hue, off, weight, sat, bri;
    longint c16, m16, c60, x60, m60, rn, gn, bn;
    pixel_t px;
    // hue in whole degrees, truncated toward zero, then floor-wrapped into 0..359
    hue = (243 + 20 * longint'(s)) / 256;
    hue = hue % 360;
    if (hue < 0) begin
      hue = hue + 360;
    end
    // registers above 1.0 count as 1.0
    sat = (sat_q8 > 9'd256) ? 256 : longint'(sat_q8);
    bri = (bri_q8 > 9'd256) ? 256 : longint'(bri_q8);
    c16 = bri * sat;
    m16 = bri * 256 - c16;
    // triangle weight 0..60 within each 120 degree span
    off = (hue % 120) - 60;
    if (off < 0) begin
      off = -off;
    end
    weight = 60 - off;
    c60 = c16 * 60;
    x60 = c16 * weight;
    m60 = m16 * 60;
    rn = 0;
    gn = 0;
    bn = 0;
    case (hwh_pkg::hwh_sector_e'(hue / 60))
      hwh_pkg::SecRedYel: begin rn = c60; gn = x60; end
      hwh_pkg::SecYelGrn: begin rn = x60; gn = c60; end
      hwh_pkg::SecGrnCyn: begin gn = c60; bn = x60; end
      hwh_pkg::SecCynBlu: begin gn = x60; bn = c60; end
      hwh_pkg::SecBluMag: begin rn = x60; bn = c60; end
      default:            begin rn = c60; bn = x60; end
    endcase
    px.red   = scale_channel(rn + m60);
    px.green = scale_channel(gn + m60);
    px.blue  = scale_channel(bn + m60);
    return px;
  endfunction

  function void note_hue_input(logic [23:0] s);
    pixel_expect_t e;
    e.smooth = s;
    e.px     = hsv_pixel(s);
    pending_pixels.push_back(e);
  endfunction

  task report(string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_expect_t e;
    if (pending_pixels.size() == 0) begin
      report($sformatf("unexpected pixel %0d/%0d/%0d", r, g, b));
    end else begin
      e = pending_pixels.pop_front();
      if (r !== e.px.red) begin
        report($sformatf("red got %0d want %0d (s=%0d sat=%0d val=%0d)",
                         r, e.px.red, $signed(e.smooth), sat_q8, bri_q8));
      end
      if (g !== e.px.green) begin
        report($sformatf("green got %0d want %0d (s=%0d sat=%0d val=%0d)",
                         g, e.px.green, $signed(e.smooth), sat_q8, bri_q8));
      end
      if (b !== e.px.blue) begin
        report($sformatf("blue got %0d want %0d (s=%0d sat=%0d val=%0d)",
                         b, e.px.blue, $signed(e.smooth), sat_q8, bri_q8));
      end
    end
  endtask
endclass

module hue_wrap_hsv_to_rgb_tb;
  import hwh_pkg::*;

  localparam int unsigned RandPerPhase = 45;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned LongHold     = 200;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [23:0] smooth_iter_q8_i = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [7:0]  red_o, green_o, blue_o;
  logic        cfg_we_i         = 1'b0;
  logic        cfg_addr_i       = RegSat;
  logic [8:0]  cfg_wdata_i      = '0;

  // idling controls, changed by the stimulus between phases
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit long_hold_req = 1'b0;

  pixel_ledger ledger = new();

  hue_wrap_hsv_to_rgb dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .smooth_iter_q8_i(smooth_iter_q8_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // beat monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        ledger.note_hue_input(smooth_iter_q8_i);
      end
      if (out_valid_o && !out_stall_i) begin
        ledger.check_pixel(red_o, green_o, blue_o);
      end
    end
  end

  // smallest non-negative s whose raw hue is k degrees
  function automatic logic [23:0] smooth_for_hue(int k);
    if (k <= 0) begin
      return 24'd0;
    end
    return 24'((256 * k - 243 + 19) / 20);
  endfunction

  function automatic logic [23:0] rand_smooth();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return smooth_for_hue(60 * $urandom_range(0, 6)) + 24'($urandom_range(0, 1));
      2: return 24'(int'($urandom_range(0, 20000)) - 10000);
      default: return smooth_for_hue($urandom_range(0, 359));
    endcase
  endfunction

  // one input beat, held until accepted; called at a rising edge
  task drive_smooth(logic [23:0] s);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    smooth_iter_q8_i <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // both registers back to back; only while the block is idle
  task write_regs(logic [8:0] sat, logic [8:0] bri);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegSat;
    cfg_wdata_i <= sat;
    @(posedge clk_i);
    ledger.set_reg(RegSat, sat);
    cfg_addr_i  <= RegVal;
    cfg_wdata_i <= bri;
    @(posedge clk_i);
    ledger.set_reg(RegVal, bri);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task wait_drained();
    int unsigned n;
    n = 0;
    while (ledger.pending_pixels.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LongHold;
      end else begin
        n = receiver_idle ? $urandom_range(0, 8) : 0;
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // stimulus
  initial begin
    logic [23:0] directed[$];
    logic [8:0]  sat_set[9];
    logic [8:0]  bri_set[9];
    int          hue_pts[10];

    sat_set = '{9'd205, 9'd0,   9'd256, 9'd511, 9'd256, 9'd0, 9'd300, 9'd0, 9'd0};
    bri_set = '{9'd256, 9'd256, 9'd256, 9'd511, 9'd0,   9'd0, 9'd137, 9'd0, 9'd0};
    sat_set[7] = 9'($urandom);
    bri_set[7] = 9'($urandom_range(0, 256));
    sat_set[8] = 9'($urandom_range(0, 256));
    bri_set[8] = 9'($urandom);
    hue_pts = '{59, 60, 61, 119, 120, 180, 240, 300, 359, 360};

    // field extremes, negative wrap, truncation toward zero, sector boundaries
    directed = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                 24'(-13), 24'(-14), 24'(-100), 24'(-4621), 24'(-4609)};
    foreach (hue_pts[i]) begin
      directed.push_back(smooth_for_hue(hue_pts[i]));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 9; p++) begin
      if (p != 0) begin
        write_regs(sat_set[p], bri_set[p]);
      end
      sender_idle   = (p != 3) && (p != 8);
      receiver_idle = (p != 5) && (p != 8);
      if (p == 3) begin
        long_hold_req = 1'b1;
      end
      if (p == 0) begin
        foreach (directed[i]) begin
          drive_smooth(directed[i]);
        end
      end
      repeat (RandPerPhase) drive_smooth(rand_smooth());
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      wait_drained();
    end

    if (ledger.pending_pixels.size() != 0) begin
      ledger.report($sformatf("%0d pixels never arrived", ledger.pending_pixels.size()));
    end
    if (ledger.errors == 0) begin
      $display("hue_wrap_hsv_to_rgb_tb passed");
    end else begin
      $display("hue_wrap_hsv_to_rgb_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("hue_wrap_hsv_to_rgb_tb failed");
    $finish;
  end

endmodule
